/* rtl/core/veu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package veu_pkg;

	// Parse phases, one per kind of word expected next
	typedef enum logic [3:0] {
		PH_LEAD    = 4'd0,
		PH_F_HDR   = 4'd1,
		PH_F_GEO   = 4'd2,
		PH_F_EMPTY = 4'd3,
		PH_F_VAL   = 4'd4,
		PH_F_CHAN  = 4'd5,
		PH_F_SKIP  = 4'd6,
		PH_F_TRL   = 4'd7,
		PH_S_HDR   = 4'd8,
		PH_S_ID    = 4'd9,
		PH_S_EMPTY = 4'd10,
		PH_S_VAL   = 4'd11,
		PH_S_CHAN  = 4'd12,
		PH_S_SKIP  = 4'd13,
		PH_S_TRL   = 4'd14,
		PH_TAIL    = 4'd15
	} phase_t;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_FIRST_COUNT  = 2'd0,
		REG_SECOND_COUNT = 2'd1,
		REG_FIRST_ADDRS  = 2'd2,
		REG_SECOND_IDS   = 2'd3
	} reg_idx_t;

	localparam logic [15:0] EMPTY_WORD     = 16'hffff;
	localparam logic [12:0] TRAILER_WORDS  = 13'd4;
	localparam int unsigned FIRST_ADDR_W   = 5;
	localparam int unsigned SECOND_ID_W    = 8;
	localparam int unsigned RES_FIFO_DEPTH = 4;

	localparam logic [1:0] FLAG_CLEAN = 2'd0;
	localparam logic [1:0] FLAG_STRAY = 2'd1;
	localparam logic [1:0] FLAG_SHORT = 2'd2;

	localparam logic KIND_HIT     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [3:0]  first_count;
		logic [3:0]  second_count;
		logic [59:0] first_addrs;
		logic [63:0] second_ids;
	} cfg_t;

	typedef struct packed {
		logic        item_kind;
		logic [3:0]  bank;
		logic [7:0]  module_address;
		logic [4:0]  channel;
		logic [11:0] sample_value;
		logic [1:0]  event_flag;
		logic        last_of_run;
	} result_t;

	// Up to two results written into the result queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		result_t    e0;
		result_t    e1;
	} push_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] bank;
	} bank_map_t;

	function automatic bank_map_t bank_of(input logic [7:0] addr);
		bank_map_t r;
		r.hit  = 1'b1;
		r.bank = 4'd0;
		if (addr >= 8'd2 && addr <= 8'd8) begin
			r.bank = 4'(addr - 8'd2);
		end else if (addr >= 8'd10 && addr <= 8'd13) begin
			r.bank = 4'(addr - 8'd3);
		end else if (addr == 8'd14) begin
			r.bank = 4'd11;
		end else if (addr == 8'd16) begin
			r.bank = 4'd12;
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/veu_channels.sv */
`timescale 1ns / 1ps
`default_nettype none

interface veu_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_word;
	logic        end_of_body;

	modport source (output valid, output data_word, output end_of_body, input ready);
	modport sink   (input valid, input data_word, input end_of_body, output ready);
endinterface

interface veu_result_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [3:0]  bank;
	logic [7:0]  module_address;
	logic [4:0]  channel;
	logic [11:0] sample_value;
	logic [1:0]  event_flag;
	logic        last_of_run;

	modport source (
		output valid, output item_kind, output bank, output module_address,
		output channel, output sample_value, output event_flag, output last_of_run,
		input ready
	);
	modport sink (
		input valid, input item_kind, input bank, input module_address,
		input channel, input sample_value, input event_flag, input last_of_run,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/vme_event_word_unpacker_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Transfer                      Payload
// words     in   valid && ready                data_word[15:0], end_of_body
// results   out  valid && ready                hit record or end-of-event summary
// APB       in   psel && penable && pwrite     4 x 64-bit registers at 8*index
//
// One body word is taken per cycle unless intake stalls; it waits in the input
// register, where the phase decode runs, and its results land in a four-entry
// result queue. A word gives at most two results (a hit and a summary); the queue
// drains at most one per cycle, so a run of summaries behind hits slows intake to
// the output rate. words.ready drops only while the queue holds over two results.
// arst_n clears the registers, the parse state and the queue; no clearing pass.
module vme_event_word_unpacker_core #(
	parameter int unsigned MAX_FIRST_SLOTS  = 12,
	parameter int unsigned MAX_SECOND_SLOTS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	veu_word_if.sink          words,
	veu_result_if.source      results,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	veu_pkg::cfg_t    cfg;
	veu_pkg::push_t   push;
	veu_pkg::result_t head;
	logic             room;
	logic [$clog2(veu_pkg::RES_FIFO_DEPTH):0] fill;

	// Configuration registers, read live by the parser
	veu_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Hold each word in the input register, decode it against the parse phase
	veu_parser #(
		.MAX_FIRST_SLOTS  (MAX_FIRST_SLOTS),
		.MAX_SECOND_SLOTS (MAX_SECOND_SLOTS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (words.valid),
		.in_word  (words.data_word),
		.in_end   (words.end_of_body),
		.in_ready (words.ready),
		.room     (room),
		.push     (push)
	);

	// Queue the results so intake keeps going while the sink stalls
	veu_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_res   (head),
		.fill      (fill)
	);

	assign results.item_kind      = head.item_kind;
	assign results.bank           = head.bank;
	assign results.module_address = head.module_address;
	assign results.channel        = head.channel;
	assign results.sample_value   = head.sample_value;
	assign results.event_flag     = head.event_flag;
	assign results.last_of_run    = head.last_of_run;

	// Intake stalls only behind queued results
	a_stall_has_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!words.ready |-> results.valid)
		else $error("word intake stalled with an empty result queue");

	// The queue never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= ($clog2(veu_pkg::RES_FIFO_DEPTH) + 1)'(veu_pkg::RES_FIFO_DEPTH))
		else $error("result queue overfilled");

	// A summary always closes the results of its word
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.item_kind == veu_pkg::KIND_SUMMARY |-> results.last_of_run)
		else $error("summary without last_of_run");

	// Hit records carry no event flag
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.item_kind == veu_pkg::KIND_HIT
		|-> results.event_flag == veu_pkg::FLAG_CLEAN)
		else $error("hit record with an event flag");

endmodule

`default_nettype wire

/* rtl/core/veu_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module veu_cfg_regs (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [4:0]     paddr,
	input  wire logic [63:0]    pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	output veu_pkg::cfg_t       cfg
);

	veu_pkg::cfg_t    cfg_q;
	veu_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = veu_pkg::reg_idx_t'(paddr[4:3]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				veu_pkg::REG_FIRST_COUNT:  cfg_q.first_count  <= pwdata[3:0];
				veu_pkg::REG_SECOND_COUNT: cfg_q.second_count <= pwdata[3:0];
				veu_pkg::REG_FIRST_ADDRS:  cfg_q.first_addrs  <= pwdata[59:0];
				veu_pkg::REG_SECOND_IDS:   cfg_q.second_ids   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			veu_pkg::REG_FIRST_COUNT:  prdata = {60'd0, cfg_q.first_count};
			veu_pkg::REG_SECOND_COUNT: prdata = {60'd0, cfg_q.second_count};
			veu_pkg::REG_FIRST_ADDRS:  prdata = {4'd0, cfg_q.first_addrs};
			veu_pkg::REG_SECOND_IDS:   prdata = cfg_q.second_ids;
			default:                   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/veu_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module veu_parser #(
	parameter int unsigned MAX_FIRST_SLOTS  = 12,
	parameter int unsigned MAX_SECOND_SLOTS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire veu_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	input  wire logic [15:0]   in_word,
	input  wire logic          in_end,
	output logic               in_ready,
	input  wire logic          room,
	output veu_pkg::push_t     push
);

	localparam logic [3:0] MaxFirst  = 4'(MAX_FIRST_SLOTS);
	localparam logic [3:0] MaxSecond = 4'(MAX_SECOND_SLOTS);

	// Input register
	logic        valid_s1;
	logic [15:0] word_s1;
	logic        end_s1;
	logic        advance;

	// Parse state
	veu_pkg::phase_t phase_q, phase_nxt;
	logic [3:0]      slot_q, slot_nxt;
	logic [12:0]     wrem_q, wrem_nxt;
	logic [11:0]     held_q, held_nxt;
	logic [7:0]      addr_q, addr_nxt;
	logic [1:0]      flag_q, flag_nxt;

	logic [3:0]  n_first, n_second;
	logic [4:0]  exp_first;
	logic [7:0]  exp_second;
	logic [12:0] wrem_dec;
	logic [12:0] sec_words;
	logic [3:0]  slot_inc;
	veu_pkg::bank_map_t map;
	veu_pkg::result_t   hit_res, sum_res;
	logic               hit_v;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
			end_s1  <= in_end;
		end
	end

	assign n_first  = (cfg.first_count > MaxFirst) ? MaxFirst : cfg.first_count;
	assign n_second = (cfg.second_count > MaxSecond) ? MaxSecond : cfg.second_count;
	assign wrem_dec = wrem_q - 13'd1;
	assign slot_inc = slot_q + 4'd1;
	assign sec_words = {word_s1[11:0], 1'b0};

	always_comb begin
		exp_first = '0;
		for (int i = 0; i < MAX_FIRST_SLOTS; i++) begin
			if (slot_q == 4'(i)) begin
				exp_first = cfg.first_addrs[i*veu_pkg::FIRST_ADDR_W +: veu_pkg::FIRST_ADDR_W];
			end
		end
	end

	always_comb begin
		exp_second = '0;
		for (int i = 0; i < MAX_SECOND_SLOTS; i++) begin
			if (slot_q == 4'(i)) begin
				exp_second = cfg.second_ids[i*veu_pkg::SECOND_ID_W +: veu_pkg::SECOND_ID_W];
			end
		end
	end

	// Next state
	always_comb begin
		phase_nxt = phase_q;
		slot_nxt  = slot_q;
		wrem_nxt  = wrem_q;
		held_nxt  = held_q;
		addr_nxt  = addr_q;
		flag_nxt  = flag_q;
		unique case (phase_q)
			veu_pkg::PH_LEAD, veu_pkg::PH_F_EMPTY: begin
				if (phase_q == veu_pkg::PH_LEAD ? (n_first != 4'd0) : (slot_inc < n_first)) begin
					phase_nxt = veu_pkg::PH_F_HDR;
					slot_nxt  = (phase_q == veu_pkg::PH_LEAD) ? 4'd0 : slot_inc;
				end else if (n_second != 4'd0) begin
					phase_nxt = veu_pkg::PH_S_HDR;
					slot_nxt  = 4'd0;
				end else begin
					phase_nxt = veu_pkg::PH_TAIL;
				end
			end
			veu_pkg::PH_F_HDR: begin
				if (word_s1 == veu_pkg::EMPTY_WORD) begin
					phase_nxt = veu_pkg::PH_F_EMPTY;
				end else begin
					wrem_nxt  = {4'd0, word_s1[15:8], 1'b0};
					phase_nxt = veu_pkg::PH_F_GEO;
				end
			end
			veu_pkg::PH_F_GEO: begin
				addr_nxt = {3'd0, word_s1[15:11]};
				if (wrem_q == 13'd0) begin
					wrem_nxt  = veu_pkg::TRAILER_WORDS;
					phase_nxt = veu_pkg::PH_F_TRL;
				end else begin
					phase_nxt = (word_s1[15:11] == exp_first) ? veu_pkg::PH_F_VAL
						: veu_pkg::PH_F_SKIP;
				end
			end
			veu_pkg::PH_F_VAL, veu_pkg::PH_S_VAL: begin
				held_nxt = word_s1[11:0];
				wrem_nxt = wrem_dec;
				if (wrem_dec == 13'd0) begin
					wrem_nxt  = veu_pkg::TRAILER_WORDS;
					phase_nxt = (phase_q == veu_pkg::PH_F_VAL) ? veu_pkg::PH_F_TRL
						: veu_pkg::PH_S_TRL;
				end else begin
					phase_nxt = (phase_q == veu_pkg::PH_F_VAL) ? veu_pkg::PH_F_CHAN
						: veu_pkg::PH_S_CHAN;
				end
			end
			veu_pkg::PH_F_CHAN, veu_pkg::PH_S_CHAN: begin
				wrem_nxt = wrem_dec;
				if (wrem_dec == 13'd0) begin
					wrem_nxt  = veu_pkg::TRAILER_WORDS;
					phase_nxt = (phase_q == veu_pkg::PH_F_CHAN) ? veu_pkg::PH_F_TRL
						: veu_pkg::PH_S_TRL;
				end else begin
					phase_nxt = (phase_q == veu_pkg::PH_F_CHAN) ? veu_pkg::PH_F_VAL
						: veu_pkg::PH_S_VAL;
				end
			end
			veu_pkg::PH_F_SKIP, veu_pkg::PH_S_SKIP: begin
				wrem_nxt = wrem_dec;
				if (wrem_dec == 13'd0) begin
					wrem_nxt  = veu_pkg::TRAILER_WORDS;
					phase_nxt = (phase_q == veu_pkg::PH_F_SKIP) ? veu_pkg::PH_F_TRL
						: veu_pkg::PH_S_TRL;
				end
			end
			veu_pkg::PH_F_TRL: begin
				wrem_nxt = wrem_dec;
				if (wrem_dec == 13'd0) begin
					if (slot_inc < n_first) begin
						phase_nxt = veu_pkg::PH_F_HDR;
						slot_nxt  = slot_inc;
					end else if (n_second != 4'd0) begin
						phase_nxt = veu_pkg::PH_S_HDR;
						slot_nxt  = 4'd0;
					end else begin
						phase_nxt = veu_pkg::PH_TAIL;
					end
				end
			end
			veu_pkg::PH_S_HDR: begin
				if (word_s1 == veu_pkg::EMPTY_WORD) begin
					phase_nxt = veu_pkg::PH_S_EMPTY;
				end else begin
					wrem_nxt  = (sec_words >= 13'd2) ? sec_words - 13'd2 : 13'd0;
					phase_nxt = veu_pkg::PH_S_ID;
				end
			end
			veu_pkg::PH_S_ID: begin
				addr_nxt = word_s1[7:0];
				if (wrem_q == 13'd0) begin
					wrem_nxt  = veu_pkg::TRAILER_WORDS;
					phase_nxt = veu_pkg::PH_S_TRL;
				end else begin
					phase_nxt = (word_s1[7:0] == exp_second) ? veu_pkg::PH_S_VAL
						: veu_pkg::PH_S_SKIP;
				end
			end
			veu_pkg::PH_S_TRL, veu_pkg::PH_S_EMPTY: begin
				wrem_nxt = (phase_q == veu_pkg::PH_S_TRL) ? wrem_dec : wrem_q;
				if (phase_q == veu_pkg::PH_S_EMPTY || wrem_dec == 13'd0) begin
					if (slot_inc < n_second) begin
						phase_nxt = veu_pkg::PH_S_HDR;
						slot_nxt  = slot_inc;
					end else begin
						phase_nxt = veu_pkg::PH_TAIL;
					end
				end
			end
			veu_pkg::PH_TAIL: begin
				if (word_s1 != veu_pkg::EMPTY_WORD) begin
					flag_nxt = veu_pkg::FLAG_STRAY;
				end
			end
			default: ;
		endcase
	end

	// Results
	assign map = veu_pkg::bank_of(addr_q);

	always_comb begin
		hit_v = (phase_q == veu_pkg::PH_F_CHAN || phase_q == veu_pkg::PH_S_CHAN) && map.hit;

		hit_res                = '0;
		hit_res.item_kind      = veu_pkg::KIND_HIT;
		hit_res.bank           = map.bank;
		hit_res.module_address = addr_q;
		hit_res.channel        = word_s1[4:0];
		hit_res.sample_value   = held_q;
		hit_res.event_flag     = veu_pkg::FLAG_CLEAN;
		hit_res.last_of_run    = !end_s1;

		sum_res             = '0;
		sum_res.item_kind   = veu_pkg::KIND_SUMMARY;
		sum_res.event_flag  = (phase_nxt != veu_pkg::PH_TAIL) ? veu_pkg::FLAG_SHORT : flag_nxt;
		sum_res.last_of_run = 1'b1;

		push.e0    = hit_v ? hit_res : sum_res;
		push.e1    = sum_res;
		push.count = advance ? (2'(hit_v) + 2'(end_s1)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= veu_pkg::PH_LEAD;
			slot_q  <= '0;
			wrem_q  <= '0;
			held_q  <= '0;
			addr_q  <= '0;
			flag_q  <= veu_pkg::FLAG_CLEAN;
		end else if (advance) begin
			if (end_s1) begin
				phase_q <= veu_pkg::PH_LEAD;
				slot_q  <= '0;
				wrem_q  <= '0;
				held_q  <= '0;
				addr_q  <= '0;
				flag_q  <= veu_pkg::FLAG_CLEAN;
			end else begin
				phase_q <= phase_nxt;
				slot_q  <= slot_nxt;
				wrem_q  <= wrem_nxt;
				held_q  <= held_nxt;
				addr_q  <= addr_nxt;
				flag_q  <= flag_nxt;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/veu_result_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module veu_result_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire veu_pkg::push_t   push,
	output logic                  room,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output veu_pkg::result_t      out_res,
	output logic [$clog2(veu_pkg::RES_FIFO_DEPTH):0] fill
);

	localparam int unsigned Depth = veu_pkg::RES_FIFO_DEPTH;
	localparam int unsigned PtrW  = $clog2(Depth);

	veu_pkg::result_t mem_q [Depth];
	logic [PtrW-1:0]  rptr_q, wptr_q, wptr_p1;
	logic [PtrW:0]    fill_q;
	logic             pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = fill_q != '0;
	assign out_res   = mem_q[rptr_q];
	// two free entries whatever the sink does this cycle
	assign room      = fill_q <= (PtrW+1)'(Depth - 2);
	assign fill      = fill_q;
	assign wptr_p1   = wptr_q + PtrW'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wptr_q] <= push.e0;
		end
		if (push.count == 2'd2) begin
			mem_q[wptr_p1] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q <= '0;
			wptr_q <= '0;
			fill_q <= '0;
		end else begin
			wptr_q <= wptr_q + PtrW'(push.count);
			rptr_q <= rptr_q + PtrW'(pop);
			fill_q <= fill_q + (PtrW+1)'(push.count) - (PtrW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

/* bench/tb_vme_event_word_unpacker_core.sv */
`timescale 1ns / 1ps

module tb_vme_event_word_unpacker_core;

	localparam int unsigned MAX_FIRST     = 12;
	localparam int unsigned MAX_SECOND    = 8;
	// The word sits in the input register and then in the result
	// queue; SETTLE_CYCLES covers any word still in flight.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 90;
	localparam int unsigned PHASE_WORDS   = 110;
	localparam int unsigned MAX_REPORTS   = 40;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_PATTERN
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	veu_word_if   w_if ();
	veu_result_if r_if ();

	vme_event_word_unpacker_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.words   (w_if),
		.results (r_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor: own copy of the registers and of the parse state
	// ---------------------------------------------------------------------
	logic [3:0]  cfg_first_n  = '0;
	logic [3:0]  cfg_second_n = '0;
	logic [59:0] cfg_addrs    = '0;
	logic [63:0] cfg_ids      = '0;

	veu_pkg::phase_t ph     = veu_pkg::PH_LEAD;
	logic [3:0]  slot_idx   = '0;
	logic [12:0] words_left = '0;
	logic [11:0] held       = '0;
	logic [7:0]  mod_addr   = '0;
	logic        addr_ok    = 1'b0;
	logic [1:0]  ev_flag    = veu_pkg::FLAG_CLEAN;

	// Hit records and summaries still owed by the block, oldest first
	veu_pkg::result_t pending_records[$];

	int unsigned errors        = 0;
	int unsigned words_sent    = 0;
	int unsigned burst_left    = 0;
	int unsigned hold_requests = 0;

	logic [15:0] body_words[$];

	// Append one word to the staged body
	function automatic void stage_word(logic [15:0] w);
		body_words.insert(body_words.size(), w);
	endfunction

	// Append one owed record behind the others
	function automatic void queue_record(veu_pkg::result_t r);
		pending_records.insert(pending_records.size(), r);
	endfunction

	// Counts above the slot limits are clamped, never wrapped
	function automatic int unsigned first_slots();
		return (cfg_first_n > MAX_FIRST) ? MAX_FIRST : int'(cfg_first_n);
	endfunction

	function automatic int unsigned second_slots();
		return (cfg_second_n > MAX_SECOND) ? MAX_SECOND : int'(cfg_second_n);
	endfunction

	function automatic void open_second(int unsigned k);
		if (k < second_slots()) begin
			slot_idx = 4'(k);
			ph = veu_pkg::PH_S_HDR;
		end else begin
			ph = veu_pkg::PH_TAIL;
		end
	endfunction

	// Past the last first-type slot fall straight into the second type
	function automatic void open_first(int unsigned k);
		if (k < first_slots()) begin
			slot_idx = 4'(k);
			ph = veu_pkg::PH_F_HDR;
		end else begin
			open_second(0);
		end
	endfunction

	// Detector bank of an address or id; -1 drops the hit
	function automatic int lookup_bank(logic [7:0] a);
		if (a >= 8'd2 && a <= 8'd8) return int'(a) - 2;
		if (a >= 8'd10 && a <= 8'd13) return int'(a) - 3;
		if (a == 8'd14) return 11;
		if (a == 8'd16) return 12;
		return -1;
	endfunction

	// Advance the parse by one body word and queue the records it owes
	function automatic void unpack_word(logic [15:0] w, logic eob);
		veu_pkg::result_t hit;
		veu_pkg::result_t summary;
		logic        got_hit;
		logic [3:0]  s;
		logic [7:0]  want_addr;
		int          b;
		int unsigned span;

		hit = '0;
		summary = '0;
		got_hit = 1'b0;
		s = slot_idx;
		want_addr = '0;

		case (ph)
			veu_pkg::PH_LEAD: begin
				open_first(0);
			end
			veu_pkg::PH_F_HDR: begin
				if (w == veu_pkg::EMPTY_WORD) begin
					ph = veu_pkg::PH_F_EMPTY;
				end else begin
					words_left = {4'b0000, w[15:8], 1'b0};
					ph = veu_pkg::PH_F_GEO;
				end
			end
			veu_pkg::PH_F_GEO: begin
				mod_addr = {3'b000, w[15:11]};
				if (s < MAX_FIRST)
					want_addr = {3'b000,
						cfg_addrs[veu_pkg::FIRST_ADDR_W*s +: veu_pkg::FIRST_ADDR_W]};
				addr_ok = (mod_addr == want_addr);
				if (words_left == 0) begin
					words_left = veu_pkg::TRAILER_WORDS;
					ph = veu_pkg::PH_F_TRL;
				end else begin
					ph = addr_ok ? veu_pkg::PH_F_VAL : veu_pkg::PH_F_SKIP;
				end
			end
			veu_pkg::PH_F_VAL, veu_pkg::PH_S_VAL: begin
				held = w[11:0];
				words_left = words_left - 13'd1;
				ph = (ph == veu_pkg::PH_F_VAL) ? veu_pkg::PH_F_CHAN : veu_pkg::PH_S_CHAN;
				// a value with no channel word closes the module data
				if (words_left == 0) begin
					words_left = veu_pkg::TRAILER_WORDS;
					ph = (ph == veu_pkg::PH_F_CHAN) ? veu_pkg::PH_F_TRL : veu_pkg::PH_S_TRL;
				end
			end
			veu_pkg::PH_F_CHAN, veu_pkg::PH_S_CHAN: begin
				b = lookup_bank(mod_addr);
				if (b >= 0) begin
					got_hit = 1'b1;
					hit.item_kind = veu_pkg::KIND_HIT;
					hit.bank = 4'(b);
					hit.module_address = mod_addr;
					hit.channel = w[4:0];
					hit.sample_value = held;
				end
				words_left = words_left - 13'd1;
				if (words_left == 0) begin
					words_left = veu_pkg::TRAILER_WORDS;
					ph = (ph == veu_pkg::PH_F_CHAN) ? veu_pkg::PH_F_TRL : veu_pkg::PH_S_TRL;
				end else begin
					ph = (ph == veu_pkg::PH_F_CHAN) ? veu_pkg::PH_F_VAL : veu_pkg::PH_S_VAL;
				end
			end
			veu_pkg::PH_F_SKIP, veu_pkg::PH_S_SKIP: begin
				words_left = words_left - 13'd1;
				if (words_left == 0) begin
					words_left = veu_pkg::TRAILER_WORDS;
					ph = (ph == veu_pkg::PH_F_SKIP) ? veu_pkg::PH_F_TRL : veu_pkg::PH_S_TRL;
				end
			end
			veu_pkg::PH_F_TRL: begin
				words_left = words_left - 13'd1;
				if (words_left == 0) open_first(32'(s) + 1);
			end
			veu_pkg::PH_F_EMPTY: begin
				open_first(32'(s) + 1);
			end
			veu_pkg::PH_S_HDR: begin
				if (w == veu_pkg::EMPTY_WORD) begin
					ph = veu_pkg::PH_S_EMPTY;
				end else begin
					span = 2 * int'(w[11:0]);
					words_left = (span >= 2) ? 13'(span - 2) : 13'd0;
					ph = veu_pkg::PH_S_ID;
				end
			end
			veu_pkg::PH_S_ID: begin
				mod_addr = w[7:0];
				if (s < MAX_SECOND)
					want_addr = cfg_ids[veu_pkg::SECOND_ID_W*s +: veu_pkg::SECOND_ID_W];
				addr_ok = (mod_addr == want_addr);
				if (words_left == 0) begin
					words_left = veu_pkg::TRAILER_WORDS;
					ph = veu_pkg::PH_S_TRL;
				end else begin
					ph = addr_ok ? veu_pkg::PH_S_VAL : veu_pkg::PH_S_SKIP;
				end
			end
			veu_pkg::PH_S_TRL: begin
				words_left = words_left - 13'd1;
				if (words_left == 0) open_second(32'(s) + 1);
			end
			veu_pkg::PH_S_EMPTY: begin
				open_second(32'(s) + 1);
			end
			default: begin
				// anything but filler after the last slot is a stray word
				if (w != veu_pkg::EMPTY_WORD) ev_flag = veu_pkg::FLAG_STRAY;
			end
		endcase

		if (got_hit) begin
			hit.last_of_run = !eob;
			queue_record(hit);
		end
		if (eob) begin
			// a body cut short outranks stray words
			if (ph != veu_pkg::PH_TAIL) ev_flag = veu_pkg::FLAG_SHORT;
			summary.item_kind = veu_pkg::KIND_SUMMARY;
			summary.event_flag = ev_flag;
			summary.last_of_run = 1'b1;
			queue_record(summary);
			ph = veu_pkg::PH_LEAD;
			slot_idx = '0;
			words_left = '0;
			held = '0;
			mod_addr = '0;
			addr_ok = 1'b0;
			ev_flag = veu_pkg::FLAG_CLEAN;
		end
	endfunction

	// ---------------------------------------------------------------------
	// Reporting and result checking
	// ---------------------------------------------------------------------
	task automatic report_error(string msg);
		errors++;
		if (errors <= MAX_REPORTS) $display("%0t ERROR %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want) report_error($sformatf("%s: got %0h, want %0h", name, got, want));
	endtask

	// Sample at the rising edge; compare each transfer with the oldest record
	always @(posedge clk) begin
		veu_pkg::result_t want;
		if (arst_n && r_if.valid && r_if.ready) begin
			if (pending_records.size() == 0) begin
				report_error($sformatf("unexpected result: kind %0d bank %0d addr %0h",
					r_if.item_kind, r_if.bank, r_if.module_address));
			end else begin
				want = pending_records.pop_front();
				check_field("item_kind", r_if.item_kind, want.item_kind);
				check_field("bank", r_if.bank, want.bank);
				check_field("module_address", r_if.module_address, want.module_address);
				check_field("channel", r_if.channel, want.channel);
				check_field("sample_value", r_if.sample_value, want.sample_value);
				check_field("event_flag", r_if.event_flag, want.event_flag);
				check_field("last_of_run", r_if.last_of_run, want.last_of_run);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: rotate between free flow, coin-toss stalls and a fixed
	// stall pattern; a hold request drops ready for a long stretch so that
	// the result queue fills and the block stalls its input
	// ---------------------------------------------------------------------
	rx_mode_t    stall_mode  = RX_FREE;
	int unsigned mode_left   = 0;
	int unsigned hold_left   = 0;
	int unsigned hold_served = 0;
	int unsigned stall_tick  = 0;

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		stall_tick++;
		if (hold_left != 0) begin
			hold_left--;
			r_if.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (stall_mode)
				RX_FREE:    r_if.ready <= 1'b1;
				RX_COIN:    r_if.ready <= 1'($urandom_range(0, 1));
				default:    r_if.ready <= (stall_tick % 5) != 0;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Sender and configuration port
	// ---------------------------------------------------------------------

	// Offer one word at the falling edge and hold it until the transfer;
	// bursts of random length are separated by random gaps
	task automatic send_word(logic [15:0] w, logic eob);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				w_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		w_if.valid <= 1'b1;
		w_if.data_word <= w;
		w_if.end_of_body <= eob;
		do @(posedge clk); while (!w_if.ready);
		unpack_word(w, eob);
		words_sent++;
	endtask

	// Send the staged body, marking its final word
	task automatic send_body();
		foreach (body_words[i]) send_word(body_words[i], i == body_words.size() - 1);
	endtask

	// Drop valid, wait for every owed record, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		w_if.valid <= 1'b0;
		burst_left = 0;
		while (pending_records.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value on the
	// edge where the access completes
	task automatic write_reg(veu_pkg::reg_idx_t idx, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			veu_pkg::REG_FIRST_COUNT:  cfg_first_n = value[3:0];
			veu_pkg::REG_SECOND_COUNT: cfg_second_n = value[3:0];
			veu_pkg::REG_FIRST_ADDRS:  cfg_addrs = value[59:0];
			default:                   cfg_ids = value;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Upper bits of the count and address writes are junk the block must drop
	task automatic set_config(logic [3:0] first_n, logic [3:0] second_n,
			logic [59:0] addrs, logic [63:0] ids);
		settle();
		write_reg(veu_pkg::REG_FIRST_COUNT, {$urandom, 28'($urandom), first_n});
		write_reg(veu_pkg::REG_SECOND_COUNT, {$urandom, 28'($urandom), second_n});
		write_reg(veu_pkg::REG_FIRST_ADDRS, {4'($urandom), addrs});
		write_reg(veu_pkg::REG_SECOND_IDS, ids);
	endtask

	// ---------------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------------
	function automatic logic [7:0] mapped_addr();
		int unsigned k;
		k = $urandom_range(0, 12);
		if (k <= 6) return 8'(k + 2);
		if (k <= 10) return 8'(k + 3);
		return (k == 11) ? 8'd14 : 8'd16;
	endfunction

	// Mostly addresses that reach a bank, some fully random ones
	function automatic logic [59:0] random_addrs();
		logic [59:0] a;
		for (int i = 0; i < MAX_FIRST; i++)
			a[5*i +: 5] = ($urandom_range(0, 3) == 0) ? 5'($urandom) : mapped_addr()[4:0];
		return a;
	endfunction

	function automatic logic [63:0] random_ids();
		logic [63:0] a;
		for (int i = 0; i < MAX_SECOND; i++)
			a[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : mapped_addr();
		return a;
	endfunction

	// Mostly a few hits per module, now and then a long module
	function automatic int unsigned hit_count();
		return ($urandom_range(0, 24) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
	endfunction

	// Stage a body laid out for the current registers, with empty slots,
	// wrong addresses, stray tail words and early ends mixed in
	task automatic make_event();
		int unsigned h;
		logic [4:0]  geo;
		logic [7:0]  id;
		body_words = {};
		stage_word(16'($urandom));
		for (int i = 0; i < first_slots(); i++) begin
			if ($urandom_range(0, 9) == 0) begin
				stage_word(veu_pkg::EMPTY_WORD);
				stage_word(16'($urandom));
				continue;
			end
			h = hit_count();
			stage_word({8'(h), 8'($urandom)});
			geo = cfg_addrs[5*i +: 5];
			if ($urandom_range(0, 6) == 0) geo ^= 5'($urandom_range(1, 31));
			stage_word({geo, 11'($urandom)});
			repeat (2 * h) stage_word(16'($urandom));
			repeat (4) stage_word(16'($urandom));
		end
		for (int i = 0; i < second_slots(); i++) begin
			if ($urandom_range(0, 9) == 0) begin
				stage_word(veu_pkg::EMPTY_WORD);
				stage_word(16'($urandom));
				continue;
			end
			// length counts the header and id pair, so a length of n carries n-1 hits
			h = hit_count() + (($urandom_range(0, 5) == 0) ? 0 : 1);
			stage_word({4'($urandom), 12'(h)});
			id = cfg_ids[8*i +: 8];
			if ($urandom_range(0, 6) == 0) id ^= 8'($urandom_range(1, 255));
			stage_word({8'($urandom), id});
			if (h >= 1) repeat (2 * h - 2) stage_word(16'($urandom));
			repeat (4) stage_word(16'($urandom));
		end
		repeat ($urandom_range(0, 3))
			stage_word(($urandom_range(0, 4) == 0) ? 16'($urandom) : veu_pkg::EMPTY_WORD);
		if ($urandom_range(0, 11) == 0 && body_words.size() > 1)
			body_words = body_words[0 : $urandom_range(0, body_words.size() - 2)];
	endtask

	// Short body of raw words, filler-heavy now and then
	task automatic make_noise();
		body_words = {};
		repeat ($urandom_range(1, 10))
			stage_word(($urandom_range(0, 3) == 0) ? veu_pkg::EMPTY_WORD : 16'($urandom));
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Both counts zero after reset: the lead word completes the parse,
	// filler stays clean and a stray word raises the stray flag
	task automatic test_zero_counts();
		body_words = '{16'h0000, veu_pkg::EMPTY_WORD, 16'h1234};
		send_body();
		body_words = '{veu_pkg::EMPTY_WORD};
		send_body();
		settle();
	endtask

	// One module of each type, hits at the field extremes: top bank from
	// the highest mapped address, bank 0 from the lowest
	task automatic test_full_event();
		set_config(4'd1, 4'd1, 60'd16, 64'h02);
		body_words = '{
			16'hffff,                                   // lead
			16'h0100, 16'h8000, 16'h0fff, 16'h001f,     // one hit, address 16
			16'h0000, 16'h0000, 16'h0000, 16'h0000,     // trailer
			16'hf002, 16'h0002, 16'hf000, 16'hffe0,     // length 2, id 2, one hit
			16'hffff, 16'hffff, 16'hffff, 16'hffff,     // trailer
			16'hffff                                    // clean tail
		};
		send_body();
		settle();
	endtask

	// The body ends on a channel word: hit first, then a short summary
	task automatic test_early_end();
		body_words = '{16'h0000, 16'h0100, 16'h8000, 16'h0abc, 16'h0015};
		send_body();
		settle();
	endtask

	// Several register settings, the extremes among them, each followed by
	// a stream of events and noise
	task automatic test_random_phases();
		logic [3:0]  first_n;
		logic [3:0]  second_n;
		logic [59:0] addrs;
		logic [63:0] ids;
		int unsigned start;
		for (int p = 0; p < 8; p++) begin
			first_n = 4'($urandom_range(0, 15));
			second_n = 4'($urandom_range(0, 15));
			addrs = random_addrs();
			ids = random_ids();
			case (p)
				0: begin first_n = 4'd12; second_n = 4'd8; end
				1: begin first_n = 4'd15; second_n = 4'd15; end  // clamped counts
				2: begin first_n = 4'd0; second_n = 4'd8; end
				3: begin first_n = 4'd12; second_n = 4'd0; end
				4: begin addrs = '1; ids = '1; end
				5: begin addrs = 60'($urandom) << 28 | 60'($urandom); end
				default: ;
			endcase
			set_config(first_n, second_n, addrs, ids);
			// hold the receiver off while words keep coming
			if (p == 0 || p == 6) hold_requests++;
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				if ($urandom_range(0, 6) == 0) make_noise();
				else make_event();
				send_body();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		w_if.valid = 1'b0;
		w_if.data_word = '0;
		w_if.end_of_body = 1'b0;
		r_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zero_counts();
		test_full_event();
		test_early_end();
		test_random_phases();
		settle();

		if (pending_records.size() != 0)
			report_error($sformatf("%0d records never arrived", pending_records.size()));
		if (errors == 0) begin
			$display("PASS vme_event_word_unpacker_core");
		end else begin
			$display("FAIL vme_event_word_unpacker_core");
		end
		$finish;
	end

	// Far beyond the slowest correct run
	initial begin
		#5000000;
		$display("FAIL vme_event_word_unpacker_core");
		$finish;
	end

endmodule
